[design/dfp_pkg.sv]
// dfp_pkg: shared constants, types and helper functions for the decimal
// to fixed-point parser; no dependencies
`default_nettype none

package dfp_pkg;

  localparam int MAX_PREC  = 24;
  localparam int INT_BITS  = 20;
  localparam int FRAC_W    = 27;
  localparam int VALUE_W   = 45;
  localparam int PREC_W    = 5;
  localparam int DIGIT_W   = 4;
  localparam int QUOT_W    = MAX_PREC;
  localparam int PREC_RST  = 12;

  localparam logic [INT_BITS-1:0] INT_MAX = {INT_BITS{1'b1}};

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take_char;
    logic load_div;
    logic div_step;
    logic make_sum;
    logic load_out;
  } dfp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [PREC_W-1:0] eff_prec;
  } dfp_status_t;

  // clamp the raw register into 1..MAX_PREC
  function automatic logic [PREC_W-1:0] eff_precision(input logic [PREC_W-1:0] p);
    logic [PREC_W-1:0] e;
    e = p;
    if (p == '0) e = PREC_W'(1);
    if (p > PREC_W'(MAX_PREC)) e = PREC_W'(MAX_PREC);
    return e;
  endfunction

  // kept fraction digits, (4*p+12)/13 for p in 1..24
  function automatic logic [DIGIT_W-1:0] frac_limit(input logic [PREC_W-1:0] p);
    logic [DIGIT_W-1:0] k;
    case (p) inside
      [5'd1:5'd3]:   k = 4'd1;
      [5'd4:5'd6]:   k = 4'd2;
      [5'd7:5'd9]:   k = 4'd3;
      [5'd10:5'd13]: k = 4'd4;
      [5'd14:5'd16]: k = 4'd5;
      [5'd17:5'd19]: k = 4'd6;
      [5'd20:5'd22]: k = 4'd7;
      default:       k = 4'd8;
    endcase
    return k;
  endfunction

  function automatic logic [FRAC_W-1:0] pow10(input logic [DIGIT_W-1:0] n);
    logic [FRAC_W-1:0] v;
    case (n)
      4'd0:    v = 27'd1;
      4'd1:    v = 27'd10;
      4'd2:    v = 27'd100;
      4'd3:    v = 27'd1000;
      4'd4:    v = 27'd10000;
      4'd5:    v = 27'd100000;
      4'd6:    v = 27'd1000000;
      4'd7:    v = 27'd10000000;
      4'd8:    v = 27'd100000000;
      default: v = 27'd1;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[design/dfp_in_if.sv]
// dfp_in_if: character input channel, valid/ready with one character a beat
// depends on dfp_pkg
`default_nettype none

interface dfp_in_if import dfp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

[design/dfp_out_if.sv]
// dfp_out_if: result channel, valid/ready with one fixed-point value a beat
// depends on dfp_pkg
`default_nettype none

interface dfp_out_if import dfp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      saturated;

  modport source (output valid, output value, output saturated, input ready);
  modport sink   (input valid, input value, input saturated, output ready);
endinterface

`default_nettype wire

[design/decimal_to_fixed_point_parser_top.sv]
// decimal_to_fixed_point_parser_top: top level, joins controller and datapath
// depends on dfp_pkg, dfp_in_if, dfp_out_if, dfp_ctrl, dfp_datapath
//
//   channel  | dir | handshake        | beat payload
//   ---------+-----+------------------+-------------------------------------
//   in_ch    | in  | valid / ready    | char_code[7:0], last
//   out_ch   | out | valid / ready    | value[44:0] signed, saturated
//   cfg      | in  | cfg_we (no wait) | cfg_wdata[4:0] = precision
//
// characters are taken one a beat, one per cycle, while the parser is idle
// after the beat marked last the block pads the fraction, runs the bit-serial
// divider for p quotient bits (p = clamped precision), forms the magnitude and
// loads the output register; the last of these steps waits while the output
// register still holds an untaken result
// rst_n is synchronous; it clears the parse state and sets precision to 12
`default_nettype none

module decimal_to_fixed_point_parser_top import dfp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  dfp_in_if.sink                 in_ch,
  dfp_out_if.source              out_ch,
  input  wire logic              cfg_we,
  input  wire logic [PREC_W-1:0] cfg_wdata
);

  dfp_cmd_t    cmd;
  dfp_status_t status;
  logic        in_ready;
  logic        out_valid;

  // controller: sequences the per-string steps and owns both handshakes
  dfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: parse registers, divider and the result register
  dfp_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .char_code     (in_ch.char_code),
    .cmd           (cmd),
    .status        (status),
    .out_value     (out_ch.value),
    .out_saturated (out_ch.saturated)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire

[design/dfp_ctrl.sv]
// dfp_ctrl: sequencing state machine for parse, pad, divide, sum and output
// depends on dfp_pkg
`default_nettype none

module dfp_ctrl import dfp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_last,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire dfp_status_t status,
  output dfp_cmd_t         cmd
);

  typedef enum logic [2:0] {S_IDLE, S_PAD, S_DIV, S_SUM, S_OUT} state_t;

  state_t            state_r, state_nxt;
  logic [PREC_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_char = 1'b1;
          if (in_last) state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        cmd.load_div = 1'b1;
        cnt_nxt      = status.eff_prec;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - PREC_W'(1);
        if (cnt_r == PREC_W'(1)) state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.make_sum = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[design/dfp_datapath.sv]
// dfp_datapath: precision register, parse state, fraction divider and result
// register; depends on dfp_pkg
`default_nettype none

module dfp_datapath import dfp_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [PREC_W-1:0]   cfg_wdata,
  input  wire logic [7:0]          char_code,
  input  wire dfp_cmd_t            cmd,
  output dfp_status_t              status,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                     out_saturated
);

  typedef enum logic [1:0] {PH_LEAD, PH_BODY, PH_STOP} phase_t;

  logic [PREC_W-1:0]  prec_r;
  logic [PREC_W-1:0]  eff_prec;
  logic [DIGIT_W-1:0] k_lim;

  phase_t             phase_r, phase_nxt;
  logic               neg_r, neg_nxt;
  logic               point_r, point_nxt;
  logic [INT_BITS-1:0] int_r, int_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic [DIGIT_W-1:0] fdig_r, fdig_nxt;
  logic               ovf_r, ovf_nxt;

  logic               is_space, is_digit, do_body;
  logic [DIGIT_W-1:0] digit;
  logic [INT_BITS+3:0] int_ext;

  // divider and result registers
  logic [FRAC_W-1:0]  rem_r;
  logic [FRAC_W-1:0]  div_r;
  logic [QUOT_W-1:0]  quot_r;
  logic [PREC_W-1:0]  shift_r;
  logic [VALUE_W-1:0] mag_r;
  logic signed [VALUE_W-1:0] value_r;
  logic               sat_r;

  logic [DIGIT_W-1:0] total, pad_n;
  logic [FRAC_W-1:0]  frac_pad;
  logic [FRAC_W:0]    rem2;
  logic               rem_ge;

  assign eff_prec        = eff_precision(prec_r);
  assign k_lim           = frac_limit(eff_prec);
  assign status.eff_prec = eff_prec;

  always_ff @(posedge clk) begin
    if (!rst_n) prec_r <= PREC_W'(PREC_RST);
    else if (cfg_we) prec_r <= cfg_wdata;
  end

  assign is_space = (char_code >= CH_TAB && char_code <= CH_CR) || char_code == CH_SPACE;
  assign is_digit = char_code >= CH_ZERO && char_code <= CH_NINE;
  assign digit    = DIGIT_W'(char_code - CH_ZERO);
  assign int_ext  = (INT_BITS+4)'(int_r) * (INT_BITS+4)'(10) + (INT_BITS+4)'(digit);

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    point_nxt = point_r;
    int_nxt   = int_r;
    frac_nxt  = frac_r;
    fdig_nxt  = fdig_r;
    ovf_nxt   = ovf_r;
    do_body   = 1'b0;
    if (cmd.load_out) begin
      phase_nxt = PH_LEAD;
      neg_nxt   = 1'b0;
      point_nxt = 1'b0;
      int_nxt   = '0;
      frac_nxt  = '0;
      fdig_nxt  = '0;
      ovf_nxt   = 1'b0;
    end else if (cmd.take_char) begin
      case (phase_r)
        PH_LEAD: begin
          if (!is_space) begin
            if (char_code == CH_NUL) begin
              phase_nxt = PH_STOP;
            end else begin
              phase_nxt = PH_BODY;
              if (char_code == CH_MINUS) neg_nxt = 1'b1;
              else if (char_code != CH_PLUS) do_body = 1'b1;
            end
          end
        end
        PH_BODY: do_body = 1'b1;
        default: ;
      endcase
      if (do_body) begin
        if (char_code == CH_POINT) begin
          if (point_r) phase_nxt = PH_STOP;
          else point_nxt = 1'b1;
        end else if (is_digit) begin
          if (point_r) begin
            if (fdig_r < k_lim) begin
              frac_nxt = FRAC_W'(frac_r * FRAC_W'(10)) + FRAC_W'(digit);
              fdig_nxt = fdig_r + DIGIT_W'(1);
            end
          end else if (int_ext > (INT_BITS+4)'(INT_MAX)) begin
            int_nxt = INT_MAX;
            ovf_nxt = 1'b1;
          end else begin
            int_nxt = int_ext[INT_BITS-1:0];
          end
        end else begin
          phase_nxt = PH_STOP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      neg_r   <= 1'b0;
      point_r <= 1'b0;
      int_r   <= '0;
      frac_r  <= '0;
      fdig_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      point_r <= point_nxt;
      int_r   <= int_nxt;
      frac_r  <= frac_nxt;
      fdig_r  <= fdig_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // pad the fraction to max(count, limit) digits
  assign total    = (fdig_r > k_lim) ? fdig_r : k_lim;
  assign pad_n    = total - fdig_r;
  assign frac_pad = FRAC_W'(frac_r * pow10(pad_n));

  // restoring long division of frac*2^p by 10^total, one quotient bit a cycle
  // the remainder stays below the divisor, so it fits in FRAC_W bits
  assign rem2   = {rem_r, 1'b0};
  assign rem_ge = rem2 >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      rem_r   <= frac_pad;
      div_r   <= pow10(total);
      quot_r  <= '0;
      shift_r <= eff_prec;
    end else if (cmd.div_step) begin
      rem_r  <= rem_ge ? FRAC_W'(rem2 - {1'b0, div_r}) : FRAC_W'(rem2);
      quot_r <= {quot_r[QUOT_W-2:0], rem_ge};
    end
    if (cmd.make_sum) begin
      mag_r <= (VALUE_W'(int_r) << shift_r) + VALUE_W'(quot_r);
    end
    if (cmd.load_out) begin
      value_r <= neg_r ? VALUE_W'(~mag_r + VALUE_W'(1)) : mag_r;
      sat_r   <= ovf_r;
    end
  end

  assign out_value     = value_r;
  assign out_saturated = sat_r;

endmodule

`default_nettype wire

[design/dfp_checker.sv]
// dfp_checker: port-level assertions for the parser top, attached by bind
// depends on dfp_pkg and decimal_to_fixed_point_parser_top
`default_nettype none

module dfp_checker import dfp_pkg::*; (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      in_last,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic signed [VALUE_W-1:0] out_value,
  input wire logic                      out_saturated
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // the closing beat of a string stops intake until the result is formed
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input still taken after the closing beat");

  // a new result appears only out of the busy phase
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without a closing beat");

  // a clamped integer part never gives a zero value
  a_sat_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_value != '0)
    else $error("saturated result with zero value");

endmodule

bind decimal_to_fixed_point_parser_top dfp_checker u_dfp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_last       (in_ch.last),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_value     (out_ch.value),
  .out_saturated (out_ch.saturated)
);

`default_nettype wire

[test/decimal_to_fixed_point_parser_top_tb.sv]
// decimal_to_fixed_point_parser_top_tb: self-checking bench for the decimal string parser
// streams character beats with bursty timing, predicts each fixed-point result in
// the bench and checks it against the result channel; depends on dfp_pkg, dfp_in_if, dfp_out_if
`timescale 1ns / 100ps

module decimal_to_fixed_point_parser_top_tb;
  import dfp_pkg::*;

  localparam int SETTLE_CYCLES = 40;    // covers the end-of-string pad, divide, sum and output work
  localparam int IDLE_LIMIT    = 2000;  // cycles with no beat on either channel
  localparam int PHASE_BEATS   = 245;   // random beats per precision setting

  // one character beat as queued for the driver
  typedef struct {
    logic [7:0] code;
    logic       is_last;
  } char_beat_t;

  // one fixed-point result beat
  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      saturated;
  } fixed_result_t;

  // parse position within the current string
  typedef enum logic [1:0] {SCAN_SPACE, SCAN_BODY, SCAN_STOP} scan_phase_t;

  // receiver stall behavior
  typedef enum logic [1:0] {TAKE_ALWAYS, TAKE_RANDOM, TAKE_PATTERN, TAKE_SLOW} take_mode_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [PREC_W-1:0]   cfg_wdata;

  dfp_in_if  in_ch ();
  dfp_out_if out_ch ();

  decimal_to_fixed_point_parser_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // bench copy of the parser state and the precision register
  // ---------------------------------------------------------------------------
  logic [PREC_W-1:0]   prec_reg   = PREC_W'(PREC_RST);
  scan_phase_t         scan_phase = SCAN_SPACE;
  logic                is_neg     = 1'b0;
  logic                got_point  = 1'b0;
  logic                int_ovf    = 1'b0;
  logic [INT_BITS-1:0] whole_acc  = '0;
  logic [FRAC_W-1:0]   frac_acc   = '0;
  logic [DIGIT_W-1:0]  frac_digs  = '0;

  char_beat_t    char_q[$];        // beats waiting for the driver
  fixed_result_t results_due[$];   // predicted results, oldest first

  int unsigned beats_queued = 0;
  int unsigned beats_taken  = 0;
  int unsigned error_count  = 0;
  int unsigned idle_cycles  = 0;

  // precision as the block uses it: 0 acts as 1, anything above 24 as 24
  function automatic int unsigned active_prec();
    int unsigned p;
    p = prec_reg;
    if (p < 1) p = 1;
    if (p > MAX_PREC) p = MAX_PREC;
    return p;
  endfunction

  // fraction digits kept at the current precision
  function automatic int unsigned kept_digits();
    int unsigned k;
    k = (active_prec() * 4 + 12) / 13;
    return (k > 8) ? 8 : k;
  endfunction

  function automatic logic [63:0] pow_ten(input int unsigned n);
    logic [63:0] v;
    v = 64'd1;
    repeat (n) v = v * 64'd10;
    return v;
  endfunction

  // digits and the decimal point; anything else stops the parse
  function automatic void absorb_body(input logic [7:0] c);
    logic [24:0] n;
    if (c == CH_POINT) begin
      if (got_point) scan_phase = SCAN_STOP;
      else got_point = 1'b1;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      if (got_point) begin
        // fraction digits past the kept count are dropped
        if (frac_digs < kept_digits() && frac_digs < 8) begin
          frac_acc  = frac_acc * FRAC_W'(10) + FRAC_W'(c - CH_ZERO);
          frac_digs = frac_digs + DIGIT_W'(1);
        end
      end else begin
        n = 25'(whole_acc) * 25'd10 + 25'(c - CH_ZERO);
        // integer part clamps at all ones and flags it
        if (n > 25'(INT_MAX)) begin
          n       = 25'(INT_MAX);
          int_ovf = 1'b1;
        end
        whole_acc = n[INT_BITS-1:0];
      end
    end else begin
      scan_phase = SCAN_STOP;
    end
  endfunction

  // expected value of the string taken so far, then clear for the next one
  function automatic void close_string();
    int unsigned         p;
    int unsigned         total;
    logic [63:0]         frac;
    logic [63:0]         mag;
    logic [VALUE_W-1:0]  mag_w;
    fixed_result_t       res;
    p     = active_prec();
    total = (frac_digs > kept_digits()) ? frac_digs : kept_digits();
    if (total > 8) total = 8;
    // missing fraction digits count as zeros
    frac = 64'(frac_acc);
    if (frac_digs < total) frac = frac * pow_ten(total - frac_digs);
    mag   = (64'(whole_acc) << p) + ((frac << p) / pow_ten(total));
    mag_w = mag[VALUE_W-1:0];
    // minus zero comes out as plain zero
    res.value     = is_neg ? -$signed(mag_w) : $signed(mag_w);
    res.saturated = int_ovf;
    results_due.push_back(res);
    scan_phase = SCAN_SPACE;
    is_neg     = 1'b0;
    got_point  = 1'b0;
    int_ovf    = 1'b0;
    whole_acc  = '0;
    frac_acc   = '0;
    frac_digs  = '0;
  endfunction

  // one accepted character beat
  function automatic void absorb_char(input logic [7:0] c, input logic is_last);
    case (scan_phase)
      SCAN_SPACE: begin
        // leading whitespace is skipped, NUL ends the parse at once
        if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) begin
        end else if (c == CH_NUL) begin
          scan_phase = SCAN_STOP;
        end else begin
          scan_phase = SCAN_BODY;
          // one sign only; the next sign stops the parse in the body
          if (c == CH_MINUS) is_neg = 1'b1;
          else if (c != CH_PLUS) absorb_body(c);
        end
      end
      SCAN_BODY: absorb_body(c);
      default: begin
        // stopped: rest of the string is ignored
      end
    endcase
    if (is_last) close_string();
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_text(input logic [7:0] text[$]);
    char_beat_t b;
    foreach (text[i]) begin
      b.code    = text[i];
      b.is_last = (i == text.size() - 1);
      char_q.push_back(b);
      beats_queued++;
    end
  endfunction

  function automatic void queue_str(input string s);
    logic [7:0] text[$];
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    queue_text(text);
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // mostly well-formed numbers with random content, the rest noise
  function automatic void queue_random_string();
    logic [7:0]  text[$];
    int unsigned n_int;
    int unsigned n_frac;
    if ($urandom_range(0, 9) < 2) begin
      repeat ($urandom_range(1, 6)) text.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
        text.push_back($urandom_range(0, 5) == 5 ? CH_SPACE
                                                 : CH_TAB + 8'($urandom_range(0, 4)));
      case ($urandom_range(0, 3))
        0: text.push_back(CH_MINUS);
        1: text.push_back(CH_PLUS);
        default: begin
        end
      endcase
      // a few long integer parts to reach the clamp
      n_int = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 3);
      repeat (n_int) text.push_back(rand_digit());
      if ($urandom_range(0, 3) != 0) begin
        text.push_back(CH_POINT);
        n_frac = $urandom_range(0, 10);
        repeat (n_frac) text.push_back(rand_digit());
      end
      // broken tail: second point, NUL, stray sign or junk, then more characters
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 3))
          0: text.push_back(CH_POINT);
          1: text.push_back(CH_NUL);
          2: text.push_back(CH_MINUS);
          default: text.push_back(8'($urandom));
        endcase
        repeat ($urandom_range(0, 3))
          text.push_back($urandom_range(0, 1) ? rand_digit() : 8'($urandom));
      end
    end
    if (text.size() == 0) text.push_back(rand_digit());
    queue_text(text);
  endfunction

  // wait until every beat went in and every result came out, then let the block go quiet
  task automatic settle_all();
    while (!(beats_taken == beats_queued && results_due.size() == 0)) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_precision(input logic [PREC_W-1:0] p);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we    <= 1'b0;
    prec_reg   = p;
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of beats with random gaps, fed from char_q
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  char_beat_t  next_beat;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.char_code <= '0;
      in_ch.last      <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        absorb_char(in_ch.char_code, in_ch.last);
        beats_taken++;
      end
      // a beat on the bus stays until it is taken
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0 || char_q.size() == 0) begin
          in_ch.valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          next_beat        = char_q.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.char_code <= next_beat.code;
          in_ch.last      <= next_beat.is_last;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks result beats and stalls ready on its own pattern
  // ---------------------------------------------------------------------------
  take_mode_t    take_mode = TAKE_ALWAYS;
  int unsigned   take_span = 0;
  logic [7:0]    take_pat  = 8'hFF;
  fixed_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          error_count++;
          $display("%0t: result beat with none expected, value=%0d saturated=%0b",
                   $time, out_ch.value, out_ch.saturated);
        end else begin
          want = results_due.pop_front();
          if (out_ch.value !== want.value) begin
            error_count++;
            $display("%0t: value mismatch, expected %0d, actual %0d",
                     $time, want.value, out_ch.value);
          end
          if (out_ch.saturated !== want.saturated) begin
            error_count++;
            $display("%0t: saturated mismatch, expected %0b, actual %0b",
                     $time, want.saturated, out_ch.saturated);
          end
        end
      end
      // pick a new stall style every so often
      if (take_span == 0) begin
        take_mode = take_mode_t'($urandom_range(0, 3));
        take_span = $urandom_range(20, 200);
        take_pat  = 8'($urandom) | 8'h01;
      end else begin
        take_span--;
      end
      case (take_mode)
        TAKE_ALWAYS:  out_ch.ready <= 1'b1;
        TAKE_RANDOM:  out_ch.ready <= 1'($urandom_range(0, 1));
        TAKE_PATTERN: begin
          out_ch.ready <= take_pat[0];
          take_pat      = {take_pat[0], take_pat[7:1]};
        end
        default:      out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: no beat on either channel for too long ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("decimal_to_fixed_point_parser_top verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // sequence: reset, directed strings at reset precision, then random phases
  // ---------------------------------------------------------------------------
  initial begin
    logic [PREC_W-1:0] prec_plan[$];
    int unsigned       target;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.last      = 1'b0;
    out_ch.ready    = 1'b0;
    // out-of-range settings, both extremes, one random setting and a fixed mid-range one
    prec_plan = '{5'd24, 5'd0, 5'd1, 5'd31, 5'd25, 5'($urandom_range(2, 23)), 5'd17};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    queue_str("\t-0");        // whitespace and minus zero
    queue_str(" +1.5");       // plus sign and a fraction
    queue_str("2000000");     // integer clamp
    queue_str("1..5");        // second point stops the parse
    queue_text('{CH_NUL});    // empty string
    queue_str("x");           // garbage only
    queue_str("-");           // sign only
    queue_text('{8'hFF});     // top character code
    settle_all();

    // each phase drains fully before the register changes
    foreach (prec_plan[i]) begin
      write_precision(prec_plan[i]);
      target = beats_queued + PHASE_BEATS;
      while (beats_queued < target) queue_random_string();
      settle_all();
    end

    if (error_count == 0 && results_due.size() == 0) begin
      $display("decimal_to_fixed_point_parser_top verification clean");
    end else begin
      $display("decimal_to_fixed_point_parser_top verification failed");
    end
    $finish;
  end

endmodule
